### hw/rtl/camera_perspective_projection_macros.svh
// Assertion macros for the camera projection block.
`ifndef CAMERA_PERSPECTIVE_PROJECTION_MACROS_SVH
`define CAMERA_PERSPECTIVE_PROJECTION_MACROS_SVH
`ifndef SYNTH
`define CPP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("camera projection check failed");
`define CPP_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("camera projection latency check failed");
`else
`define CPP_ASSERT_IMPL(lbl, ante, cons)
`define CPP_ASSERT_DELAY(lbl, ante, n, cons)
`endif
`endif

### hw/rtl/cpp_pkg.sv
`default_nettype none
package cpp_pkg;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned ProdW    = 49;
  localparam int unsigned SumW     = 51;
  localparam int unsigned CoordW   = 37;
  localparam int unsigned MulW     = 54;
  localparam int unsigned QuotBits = 18;
  localparam int unsigned FrontStages = 5;
  localparam int unsigned Latency  = FrontStages + QuotBits + 1;

  typedef enum logic [2:0] {
    RegPosX, RegPosY, RegPosZ, RegRight, RegUp, RegView, RegFocal, RegHalf
  } reg_idx_e;

  typedef struct packed {
    logic                valid;
    logic                behind;
    logic                neg_x;
    logic                neg_y;
    logic                ovf_x;
    logic                ovf_y;
    logic [30:0]         depth;
    logic [CoordW-1:0]   div;
    logic [MulW-1:0]     rem_x;
    logic [MulW-1:0]     rem_y;
    logic [QuotBits-1:0] q_x;
    logic [QuotBits-1:0] q_y;
  } cell_t;
endpackage
`default_nettype wire

### hw/rtl/cpp_cell.sv
`default_nettype none
module cpp_cell #(
  parameter int unsigned Bit = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cpp_pkg::cell_t     cell_i,
  output cpp_pkg::cell_t     cell_o
);
  import cpp_pkg::*;

  logic [MulW:0] trial;
  logic          ge_x, ge_y;
  cell_t         cell_d, data_q;
  logic          valid_q;

  assign trial = {{(MulW + 1 - CoordW){1'b0}}, cell_i.div} << Bit;
  assign ge_x  = {1'b0, cell_i.rem_x} >= trial;
  assign ge_y  = {1'b0, cell_i.rem_y} >= trial;

  always_comb begin
    cell_d = cell_i;
    if (ge_x) begin
      cell_d.rem_x    = cell_i.rem_x - trial[MulW-1:0];
      cell_d.q_x[Bit] = 1'b1;
    end
    if (ge_y) begin
      cell_d.rem_y    = cell_i.rem_y - trial[MulW-1:0];
      cell_d.q_y[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= cell_d;
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end
endmodule
`default_nettype wire

### hw/rtl/cpp_front.sv
`default_nettype none
module cpp_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] point_z_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [47:0] right_i,
  input  wire logic [47:0] up_i,
  input  wire logic [47:0] view_i,
  input  wire logic [15:0] focal_i,
  output cpp_pkg::cell_t   cell_o
);
  import cpp_pkg::*;

  logic [FrontStages-1:0] v_q;

  logic signed [DiffW-1:0] d_q [3];
  logic signed [ProdW-1:0] p_q [3][3];
  logic signed [CoordW-1:0] c_q [3];
  logic signed [MulW-1:0]   mx_q, my_q;
  logic signed [CoordW-1:0] cz4_q;
  cell_t                    out_q;

  logic [47:0]              axes [3];
  logic signed [SumW-1:0]   sums [3];
  logic signed [MulW-1:0]   mx_d, my_d;
  logic [MulW-1:0]          abs_x, abs_y;
  logic [MulW:0]            limit;
  logic                     behind;

  assign axes[0] = right_i;
  assign axes[1] = up_i;
  assign axes[2] = view_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sums[a] = SumW'(p_q[a][0]) + SumW'(p_q[a][1]) + SumW'(p_q[a][2]);
    end
  end

  assign mx_d   = c_q[0] * $signed({1'b0, focal_i});
  assign my_d   = c_q[1] * $signed({1'b0, focal_i});
  assign abs_x  = mx_q[MulW-1] ? MulW'(-mx_q) : MulW'(mx_q);
  assign abs_y  = my_q[MulW-1] ? MulW'(-my_q) : MulW'(my_q);
  assign limit  = {{(MulW + 1 - CoordW - QuotBits){1'b0}}, cz4_q, {QuotBits{1'b0}}};
  assign behind = cz4_q[CoordW-1] || (cz4_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0] <= $signed({point_x_i[31], point_x_i}) - $signed({pos_x_i[31], pos_x_i});
    d_q[1] <= $signed({point_y_i[31], point_y_i}) - $signed({pos_y_i[31], pos_y_i});
    d_q[2] <= $signed({point_z_i[31], point_z_i}) - $signed({pos_z_i[31], pos_z_i});
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        p_q[a][k] <= d_q[k] * $signed(axes[a][16*k +: 16]);
      end
      c_q[a] <= sums[a][SumW-1:14];
    end
    mx_q  <= mx_d;
    my_q  <= my_d;
    cz4_q <= c_q[2];
    out_q.valid  <= v_q[FrontStages-2];
    out_q.behind <= behind;
    out_q.neg_x  <= mx_q[MulW-1];
    out_q.neg_y  <= my_q[MulW-1];
    out_q.ovf_x  <= {1'b0, abs_x} >= limit;
    out_q.ovf_y  <= {1'b0, abs_y} >= limit;
    out_q.depth  <= (cz4_q[CoordW-1:31] != '0) ? 31'h7FFF_FFFF : cz4_q[30:0];
    out_q.div    <= cz4_q;
    out_q.rem_x  <= abs_x;
    out_q.rem_y  <= abs_y;
    out_q.q_x    <= '0;
    out_q.q_y    <= '0;
  end

  always_comb begin
    cell_o       = out_q;
    cell_o.valid = v_q[FrontStages-1];
  end
endmodule
`default_nettype wire

### hw/rtl/camera_perspective_projection.sv
// Pinhole projection of world-space vertices through a camera held in registers.
// The user must write the camera through the APB port only while the block is
// idle; the block does not enforce this. Register i sits at byte address 8*i and
// reads back its value. pready is always high. A vertex item is taken at each
// rising edge with start high and busy low. busy is never raised, so one item can
// enter in every cycle. Each item yields exactly one result through five front
// stages (offset, products, dot sums, focal scaling, division set-up), a chain
// of eighteen divider cells that each settle one quotient bit, and the output
// register. done_o marks the result for a single cycle and the receiver must
// take it then, as it cannot stall the block.
// Quotients beyond eighteen bits are flagged before the cells and saturated after.
// A vertex at zero or negative depth is flagged behind with zero outputs.
// Reset restores the default camera and drops every item in flight.
`default_nettype none
module camera_perspective_projection (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output logic             done_o,
  output logic             behind_o,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic      [30:0] depth_o
);
  import cpp_pkg::*;
  `include "camera_perspective_projection_macros.svh"

  logic [31:0] pos_x_q, pos_y_q, pos_z_q, half_q;
  logic [47:0] right_q, up_q, view_q;
  logic [15:0] focal_q;
  reg_idx_e    idx;
  logic        wr;

  cell_t chain [QuotBits+1];

  logic [QuotBits-1:0]    mag_x, mag_y;
  logic signed [QuotBits:0] val_x, val_y;
  logic signed [20:0]     sx, sy;
  logic signed [15:0]     sx_c, sy_c;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      right_q <= 48'd16384;
      up_q    <= 48'd1 << 30;
      view_q  <= 48'd1 << 46;
      focal_q <= 16'd256;
      half_q  <= 32'h00F0_0140;
    end else if (wr) begin
      unique case (idx)
        RegPosX:  pos_x_q <= pwdata[31:0];
        RegPosY:  pos_y_q <= pwdata[31:0];
        RegPosZ:  pos_z_q <= pwdata[31:0];
        RegRight: right_q <= pwdata[47:0];
        RegUp:    up_q    <= pwdata[47:0];
        RegView:  view_q  <= pwdata[47:0];
        RegFocal: focal_q <= pwdata[15:0];
        RegHalf:  half_q  <= pwdata[31:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegPosX:  prdata = {32'd0, pos_x_q};
      RegPosY:  prdata = {32'd0, pos_y_q};
      RegPosZ:  prdata = {32'd0, pos_z_q};
      RegRight: prdata = {16'd0, right_q};
      RegUp:    prdata = {16'd0, up_q};
      RegView:  prdata = {16'd0, view_q};
      RegFocal: prdata = {48'd0, focal_q};
      RegHalf:  prdata = {32'd0, half_q};
      default:  prdata = '0;
    endcase
  end

  cpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .pos_x_i   (pos_x_q),
    .pos_y_i   (pos_y_q),
    .pos_z_i   (pos_z_q),
    .right_i   (right_q),
    .up_i      (up_q),
    .view_i    (view_q),
    .focal_i   (focal_q),
    .cell_o    (chain[QuotBits])
  );

  for (genvar g = 0; g < QuotBits; g++) begin : g_cell
    cpp_cell #(.Bit(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g+1]),
      .cell_o (chain[g])
    );
  end

  assign mag_x = chain[0].ovf_x ? '1 : chain[0].q_x;
  assign mag_y = chain[0].ovf_y ? '1 : chain[0].q_y;
  assign val_x = chain[0].neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
  assign val_y = chain[0].neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
  assign sx    = 21'(val_x) + $signed({5'd0, half_q[15:0]});
  assign sy    = $signed({5'd0, half_q[31:16]}) - 21'(val_y);

  always_comb begin
    if (sx > 21'sd32767) begin
      sx_c = 16'sh7FFF;
    end else if (sx < -21'sd32768) begin
      sx_c = -16'sh8000;
    end else begin
      sx_c = sx[15:0];
    end
    if (sy > 21'sd32767) begin
      sy_c = 16'sh7FFF;
    end else if (sy < -21'sd32768) begin
      sy_c = -16'sh8000;
    end else begin
      sy_c = sy[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= chain[0].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    behind_o   <= chain[0].behind;
    screen_x_o <= chain[0].behind ? '0 : sx_c;
    screen_y_o <= chain[0].behind ? '0 : sy_c;
    depth_o    <= chain[0].behind ? '0 : chain[0].depth;
  end

  `CPP_ASSERT_DELAY(a_latency, start && !busy, Latency, done_o)
  `CPP_ASSERT_IMPL(a_behind_zero, done_o && behind_o,
                   screen_x_o == 0 && screen_y_o == 0 && depth_o == 0)
  `CPP_ASSERT_IMPL(a_depth_front, done_o && !behind_o, depth_o != 0)
endmodule
`default_nettype wire
